@@ design/eiph_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package eiph_pkg;

   // Counter width; result ports show the low 32 bits
   localparam int COUNT_WIDTH = 32;

   localparam int OFFSET_WIDTH = 17;

   // IPv4 protocol numbers
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   // Byte offsets within a frame
   localparam logic [OFFSET_WIDTH-1:0] OFF_DMAC_LAST  = 17'd5;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SMAC_LAST  = 17'd11;
   localparam logic [OFFSET_WIDTH-1:0] OFF_LEN_HI     = 17'd16;
   localparam logic [OFFSET_WIDTH-1:0] OFF_LEN_LO     = 17'd17;
   localparam logic [OFFSET_WIDTH-1:0] OFF_PROTO      = 17'd23;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SIP_FIRST  = 17'd26;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SIP_LAST   = 17'd29;
   localparam logic [OFFSET_WIDTH-1:0] OFF_DIP_FIRST  = 17'd30;
   localparam logic [OFFSET_WIDTH-1:0] OFF_DIP_LAST   = 17'd33;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SPORT_FIRST = 17'd34;
   localparam logic [OFFSET_WIDTH-1:0] OFF_SPORT_LAST  = 17'd35;
   localparam logic [OFFSET_WIDTH-1:0] OFF_DPORT_FIRST = 17'd36;
   localparam logic [OFFSET_WIDTH-1:0] OFF_DPORT_LAST  = 17'd37;

   // Header ends and Ethernet header size
   localparam logic [OFFSET_WIDTH-1:0] HDR_END_PORTS = 17'd38;
   localparam logic [OFFSET_WIDTH-1:0] HDR_END_PLAIN = 17'd34;
   localparam logic [OFFSET_WIDTH-1:0] ETH_HDR_BYTES = 17'd14;

   typedef enum logic [1:0] {
      KIND_TCP   = 2'd0,
      KIND_UDP   = 2'd1,
      KIND_ICMP  = 2'd2,
      KIND_OTHER = 2'd3
   } proto_kind_type;

endpackage

`default_nettype wire

@@ design/ethernet_ipv4_header_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Ethernet / IPv4 header parser.
// The req channel carries a stream of back-to-back frames, one byte per item.
// Each byte is decoded by its offset in the frame: both MACs, IPv4 total
// length, protocol, both IP addresses and, for TCP and UDP, both ports.
// The IPv4 header is taken as a fixed 20 bytes.
// On the last byte of a frame (14 + total length, but never before the
// header end) one item goes out on the rsp channel with the fields and the
// running frame, TCP, UDP and ICMP counts, which wrap.
// Throughput: one byte per cycle while req_stall is low. The result shows
// on rsp_valid in the cycle after its last byte is accepted; one byte decode
// and one 17-bit add/compare sit between the state and result registers.
// When the receiver stalls while a result is held, req_stall rises and the
// stream holds until the result is taken; a result taken in the same cycle
// frees the input at once.
// Reset clears the byte offset, the captured header fields, the counters and
// the result valid; the next byte is taken as the first byte of a frame.
module ethernet_ipv4_header_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [47:0]      rsp_dest_mac,
   output logic [47:0]      rsp_source_mac,
   output logic [1:0]       rsp_proto_kind,
   output logic [31:0]      rsp_source_ip,
   output logic [31:0]      rsp_dest_ip,
   output logic [15:0]      rsp_source_port,
   output logic [15:0]      rsp_dest_port,
   output logic [16:0]      rsp_frame_length,
   output logic [31:0]      rsp_frames_seen,
   output logic [31:0]      rsp_tcp_seen,
   output logic [31:0]      rsp_udp_seen,
   output logic [31:0]      rsp_icmp_seen
);

   localparam int OW = eiph_pkg::OFFSET_WIDTH;
   localparam int CW = eiph_pkg::COUNT_WIDTH;

   // Frame state
   logic [OW-1:0] offset_ff, offset_in;
   logic [47:0]   dmac_ff, dmac_in;
   logic [47:0]   smac_ff, smac_in;
   logic [15:0]   len_ff, len_in;
   logic [7:0]    proto_ff, proto_in;
   logic [31:0]   sip_ff, sip_in;
   logic [31:0]   dip_ff, dip_in;
   logic [15:0]   sport_ff, sport_in;
   logic [15:0]   dport_ff, dport_in;

   // Counters
   logic [CW-1:0] frame_cnt_ff, frame_cnt_in;
   logic [CW-1:0] tcp_cnt_ff, tcp_cnt_in;
   logic [CW-1:0] udp_cnt_ff, udp_cnt_in;
   logic [CW-1:0] icmp_cnt_ff, icmp_cnt_in;

   // Result register
   logic                     out_valid_ff, out_valid_in;
   logic [47:0]              out_dmac_ff;
   logic [47:0]              out_smac_ff;
   eiph_pkg::proto_kind_type out_kind_ff, kind;
   logic [31:0]              out_sip_ff;
   logic [31:0]              out_dip_ff;
   logic [15:0]              out_sport_ff;
   logic [15:0]              out_dport_ff;
   logic [16:0]              out_flen_ff;
   logic [31:0]              out_frames_ff;
   logic [31:0]              out_tcp_ff;
   logic [31:0]              out_udp_ff;
   logic [31:0]              out_icmp_ff;

   logic          accept;
   logic          has_ports;
   logic          last_byte;
   logic [OW-1:0] offset_next;
   logic [OW-1:0] hdr_end;
   logic [OW-1:0] frame_end;
   logic [OW-1:0] length_field;

   // Hold input while a result waits and the receiver stalls
   assign req_stall = out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Decode one byte by its offset
   always_comb begin
      dmac_in  = dmac_ff;
      smac_in  = smac_ff;
      len_in   = len_ff;
      proto_in = proto_ff;
      sip_in   = sip_ff;
      dip_in   = dip_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;

      if (offset_ff == '0) begin
         sport_in = '0;
         dport_in = '0;
      end

      if (offset_ff <= eiph_pkg::OFF_DMAC_LAST) begin
         dmac_in = {dmac_ff[39:0], req_stream_byte};
      end else if (offset_ff <= eiph_pkg::OFF_SMAC_LAST) begin
         smac_in = {smac_ff[39:0], req_stream_byte};
      end else if (offset_ff == eiph_pkg::OFF_LEN_HI || offset_ff == eiph_pkg::OFF_LEN_LO) begin
         len_in = {len_ff[7:0], req_stream_byte};
      end else if (offset_ff == eiph_pkg::OFF_PROTO) begin
         proto_in = req_stream_byte;
      end else if (offset_ff inside {[eiph_pkg::OFF_SIP_FIRST:eiph_pkg::OFF_SIP_LAST]}) begin
         sip_in = {sip_ff[23:0], req_stream_byte};
      end else if (offset_ff inside {[eiph_pkg::OFF_DIP_FIRST:eiph_pkg::OFF_DIP_LAST]}) begin
         dip_in = {dip_ff[23:0], req_stream_byte};
      end else if (offset_ff inside {[eiph_pkg::OFF_SPORT_FIRST:eiph_pkg::OFF_SPORT_LAST]}
                   && (proto_ff == eiph_pkg::PROTO_TCP || proto_ff == eiph_pkg::PROTO_UDP)) begin
         sport_in = {sport_in[7:0], req_stream_byte};
      end else if (offset_ff inside {[eiph_pkg::OFF_DPORT_FIRST:eiph_pkg::OFF_DPORT_LAST]}
                   && (proto_ff == eiph_pkg::PROTO_TCP || proto_ff == eiph_pkg::PROTO_UDP)) begin
         dport_in = {dport_in[7:0], req_stream_byte};
      end
   end

   // Find the frame end from the updated header fields
   always_comb begin
      has_ports    = (proto_in == eiph_pkg::PROTO_TCP) || (proto_in == eiph_pkg::PROTO_UDP);
      hdr_end      = has_ports ? eiph_pkg::HDR_END_PORTS : eiph_pkg::HDR_END_PLAIN;
      length_field = {1'b0, len_in} + eiph_pkg::ETH_HDR_BYTES;
      frame_end    = (length_field < hdr_end) ? hdr_end : length_field;
      offset_next  = offset_ff + 1'b1;
      last_byte    = ~(offset_next < frame_end);
      offset_in    = last_byte ? '0 : offset_next;
   end

   // Classify the protocol and advance the counters at frame end
   always_comb begin
      frame_cnt_in = frame_cnt_ff + 1'b1;
      tcp_cnt_in   = tcp_cnt_ff;
      udp_cnt_in   = udp_cnt_ff;
      icmp_cnt_in  = icmp_cnt_ff;
      case (proto_in)
         eiph_pkg::PROTO_TCP: begin
            kind       = eiph_pkg::KIND_TCP;
            tcp_cnt_in = tcp_cnt_ff + 1'b1;
         end
         eiph_pkg::PROTO_UDP: begin
            kind       = eiph_pkg::KIND_UDP;
            udp_cnt_in = udp_cnt_ff + 1'b1;
         end
         eiph_pkg::PROTO_ICMP: begin
            kind        = eiph_pkg::KIND_ICMP;
            icmp_cnt_in = icmp_cnt_ff + 1'b1;
         end
         default: begin
            kind = eiph_pkg::KIND_OTHER;
         end
      endcase
   end

   // Result valid: set on a frame's last byte, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept && last_byte) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         frame_cnt_ff <= '0;
         tcp_cnt_ff   <= '0;
         udp_cnt_ff   <= '0;
         icmp_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (accept) begin
            offset_ff <= offset_in;
            if (last_byte) begin
               frame_cnt_ff <= frame_cnt_in;
               tcp_cnt_ff   <= tcp_cnt_in;
               udp_cnt_ff   <= udp_cnt_in;
               icmp_cnt_ff  <= icmp_cnt_in;
            end
         end
      end
   end

   // Captured header fields
   always_ff @(posedge clock) begin
      if (reset) begin
         dmac_ff  <= '0;
         smac_ff  <= '0;
         len_ff   <= '0;
         proto_ff <= '0;
         sip_ff   <= '0;
         dip_ff   <= '0;
         sport_ff <= '0;
         dport_ff <= '0;
      end else if (accept) begin
         dmac_ff  <= dmac_in;
         smac_ff  <= smac_in;
         len_ff   <= len_in;
         proto_ff <= proto_in;
         sip_ff   <= sip_in;
         dip_ff   <= dip_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
      end
   end

   // Load the result register on a frame's last byte
   always_ff @(posedge clock) begin
      if (accept && last_byte) begin
         out_dmac_ff   <= dmac_in;
         out_smac_ff   <= smac_in;
         out_kind_ff   <= kind;
         out_sip_ff    <= sip_in;
         out_dip_ff    <= dip_in;
         out_sport_ff  <= has_ports ? sport_in : 16'd0;
         out_dport_ff  <= has_ports ? dport_in : 16'd0;
         out_flen_ff   <= length_field;
         out_frames_ff <= 32'(frame_cnt_in);
         out_tcp_ff    <= 32'(tcp_cnt_in);
         out_udp_ff    <= 32'(udp_cnt_in);
         out_icmp_ff   <= 32'(icmp_cnt_in);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_dest_mac     = out_dmac_ff;
   assign rsp_source_mac   = out_smac_ff;
   assign rsp_proto_kind   = out_kind_ff;
   assign rsp_source_ip    = out_sip_ff;
   assign rsp_dest_ip      = out_dip_ff;
   assign rsp_source_port  = out_sport_ff;
   assign rsp_dest_port    = out_dport_ff;
   assign rsp_frame_length = out_flen_ff;
   assign rsp_frames_seen  = out_frames_ff;
   assign rsp_tcp_seen     = out_tcp_ff;
   assign rsp_udp_seen     = out_udp_ff;
   assign rsp_icmp_seen    = out_icmp_ff;

endmodule

`default_nettype wire
